/* hdl/pbu_pkg.sv */
// pbu_pkg: shared types and codes for the pwm pattern buffer updater
// request and response beats, request modes, walk command kinds
// no dependencies
package pbu_pkg;

  localparam int MASK_W = 16;
  localparam int DUTY_W = 16;
  localparam int IDX_W  = 8;
  localparam int WORD_W = 32;

  // request modes
  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // the only served port
  localparam logic [3:0] PORT_A = 4'd0;

  // walk kinds
  localparam logic [1:0] WALK_CLEAR = 2'd0;
  localparam logic [1:0] WALK_MERGE = 2'd1;
  localparam logic [1:0] WALK_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [3:0]        port_select;
    logic [MASK_W-1:0] pin_mask;
    logic [DUTY_W-1:0] duty_steps;
    logic [IDX_W-1:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic              accepted;
    logic [WORD_W-1:0] pattern_word;
  } rsp_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [MASK_W-1:0] mask;
  } walk_cmd_t;

  // set/reset word update: low half drives high, high half drives low
  function automatic logic [WORD_W-1:0] merge_word(input logic [WORD_W-1:0] old,
                                                   input logic [MASK_W-1:0] mask,
                                                   input logic high);
    logic [WORD_W-1:0] lo_bits;
    logic [WORD_W-1:0] hi_bits;
    lo_bits = {{(WORD_W-MASK_W){1'b0}}, mask};
    hi_bits = {mask, {(WORD_W-MASK_W){1'b0}}};
    if (high) begin
      merge_word = (old & ~hi_bits) | lo_bits;
    end else begin
      merge_word = (old & ~lo_bits) | hi_bits;
    end
  endfunction

endpackage

/* hdl/pwm_pattern_buffer_updater.sv */
// pwm_pattern_buffer_updater: request decode, duty cache and response register
// depends on pbu_pkg and pbu_walk
//
// A request beat is taken when start is high and busy is low; its single
// response beat appears on rsp for one cycle, marked by done, and cannot be
// held off. Requests that touch no entries (other port, unused mode, a mask
// with no pin, an unchanged duty, a read beyond the store) answer on the
// cycle after acceptance. Otherwise one entry walker reads the pattern store
// and, on non-reads, rewrites it at one entry per cycle; the answer follows
// the walk over the covered entries: all STEPS entries for a clear or a first
// duty write on a pin, those between old and new duty for a cached pin, one
// for a read. After reset the store is swept to zero while busy is held high.
module pwm_pattern_buffer_updater import pbu_pkg::*; #(
  parameter int STEPS = 256,
  parameter int PINS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int CW = $clog2(STEPS+1);
  localparam int PW = (PINS > 1) ? $clog2(PINS) : 1;

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_SWEEP = 2'd3;

  logic [1:0]      state;
  logic            pend_read;
  logic [PINS-1:0] valid_bits;
  logic [CW-1:0]   cached_duty [PINS];

  logic            accept;
  logic            port_ok;
  logic            pin_found;
  logic [PW-1:0]   pin;
  logic [CW-1:0]   duty_sat;
  logic [CW-1:0]   old_duty;
  logic            idx_ok;

  logic            go;
  walk_cmd_t       cmd;
  logic [CW-1:0]   lo;
  logic [CW-1:0]   hi;
  logic            walk_done;
  logic [WORD_W-1:0] rword;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign port_ok = (req.port_select == PORT_A);
  assign idx_ok  = (32'(req.entry_index) < 32'(STEPS));

  // lowest pin of the mask below PINS
  always_comb begin
    pin_found = 1'b0;
    pin       = '0;
    for (int i = PINS - 1; i >= 0; i--) begin
      if (req.pin_mask[i]) begin
        pin_found = 1'b1;
        pin       = PW'(i);
      end
    end
  end

  // saturated duty and cached duty of the selected pin
  assign duty_sat = (32'(req.duty_steps) > 32'(STEPS)) ? CW'(STEPS) : CW'(req.duty_steps);
  assign old_duty = cached_duty[pin];

  // walk launch and range
  always_comb begin
    go       = 1'b0;
    cmd.kind = WALK_CLEAR;
    cmd.mask = req.pin_mask;
    lo       = '0;
    hi       = CW'(STEPS);
    if (state == ST_INIT) begin
      go = 1'b1;
    end else if (accept && port_ok) begin
      unique case (req.mode)
        MODE_SET: begin
          cmd.kind = WALK_MERGE;
          if (valid_bits[pin]) begin
            if (duty_sat > old_duty) begin
              lo = old_duty;
              hi = duty_sat;
            end else begin
              lo = duty_sat;
              hi = old_duty;
            end
          end
          go = pin_found && (lo != hi);
        end
        MODE_CLEAR: begin
          go = 1'b1;
        end
        MODE_READ: begin
          cmd.kind = WALK_READ;
          lo       = CW'(req.entry_index);
          hi       = CW'(req.entry_index) + CW'(1);
          go       = idx_ok;
        end
        default: begin
          go = 1'b0;
        end
      endcase
    end
  end

  // sequencer and response
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      done       <= 1'b0;
      valid_bits <= '0;
      pend_read  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_INIT: begin
          state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          // power-up clear of the store, no response beat
          if (walk_done) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            pend_read <= (req.mode == MODE_READ);
            if (port_ok && req.mode == MODE_SET && pin_found) begin
              valid_bits[pin] <= 1'b1;
            end
            if (port_ok && req.mode == MODE_CLEAR) begin
              valid_bits <= '0;
            end
            if (go) begin
              state <= ST_WAIT;
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_WAIT: begin
          if (walk_done) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // response payload and duty cache
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.accepted     <= port_ok && (req.mode != MODE_UNUSED);
      rsp.pattern_word <= '0;
      if (port_ok && req.mode == MODE_SET && pin_found) begin
        cached_duty[pin] <= duty_sat;
      end
    end else if (state == ST_WAIT && walk_done) begin
      rsp.accepted     <= 1'b1;
      rsp.pattern_word <= pend_read ? rword : '0;
    end
  end

  pbu_walk #(
    .STEPS(STEPS)
  ) u_walk (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .cmd  (cmd),
    .lo   (lo),
    .hi   (hi),
    .duty (duty_sat),
    .done (walk_done),
    .rword(rword)
  );

endmodule

/* hdl/pbu_store.sv */
// pbu_store: pattern word memory, one write port, one registered read port
// depends on pbu_pkg for the word width
module pbu_store import pbu_pkg::*; #(
  parameter int STEPS = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(STEPS)-1:0] waddr,
  input  logic [WORD_W-1:0]        wdata,
  input  logic [$clog2(STEPS)-1:0] raddr,
  output logic [WORD_W-1:0]        rdata
);

  logic [WORD_W-1:0] mem [STEPS];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/pbu_walk.sv */
// pbu_walk: entry walker over the pattern store, one read-modify-write per cycle
// depends on pbu_pkg and pbu_store
module pbu_walk import pbu_pkg::*; #(
  parameter int STEPS = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  walk_cmd_t                  cmd,
  input  logic [$clog2(STEPS+1)-1:0] lo,
  input  logic [$clog2(STEPS+1)-1:0] hi,
  input  logic [$clog2(STEPS+1)-1:0] duty,
  output logic                       done,
  output logic [WORD_W-1:0]          rword
);

  localparam int AW = $clog2(STEPS);
  localparam int CW = $clog2(STEPS+1);

  logic          run;
  logic [CW-1:0] ptr;
  logic [CW-1:0] ptr_next;
  logic [CW-1:0] hi_r;
  logic [CW-1:0] duty_r;
  walk_cmd_t     cmd_r;
  logic          s1_vld;
  logic          s1_last;
  logic [CW-1:0] s1_addr;
  logic          we;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;

  assign ptr_next = ptr + CW'(1);

  // walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      run     <= 1'b0;
      s1_vld  <= 1'b0;
      s1_last <= 1'b0;
    end else begin
      if (go) begin
        run <= 1'b1;
      end else if (run && ptr_next == hi_r) begin
        run <= 1'b0;
      end
      s1_vld  <= run;
      s1_last <= run && (ptr_next == hi_r);
    end
  end

  // walk range and command
  always_ff @(posedge clk) begin
    if (go) begin
      ptr    <= lo;
      hi_r   <= hi;
      duty_r <= duty;
      cmd_r  <= cmd;
    end else if (run) begin
      ptr <= ptr_next;
    end
    s1_addr <= ptr;
  end

  // write-back stage: merge sets entries below duty high, rest low; clear zeroes
  always_comb begin
    we    = s1_vld && (cmd_r.kind != WALK_READ);
    wdata = '0;
    if (cmd_r.kind == WALK_MERGE) begin
      wdata = merge_word(rdata, cmd_r.mask, s1_addr < duty_r);
    end
  end

  assign done  = s1_vld && s1_last;
  assign rword = rdata;

  pbu_store #(
    .STEPS(STEPS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(s1_addr[AW-1:0]),
    .wdata(wdata),
    .raddr(ptr[AW-1:0]),
    .rdata(rdata)
  );

endmodule

/* tb/pbu_checker.sv */
`timescale 1ns / 1ps
// pbu_checker: predicts every response beat of the pwm pattern buffer updater and checks it
// watches the request and response channels beside the block; depends on pbu_pkg
module pbu_checker import pbu_pkg::*; #(
  parameter int STEPS = 256,
  parameter int PINS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic done,
  input  rsp_t rsp,
  input  logic drain_check,
  output int   pending,
  output int   errors
);

  // predicted pattern store, per-pin duty cache and cache valid mask
  logic [WORD_W-1:0] pattern_mem [STEPS];
  int                pin_duty    [PINS];
  logic [MASK_W-1:0] duty_known;

  rsp_t expected_rsp [$];
  rsp_t oldest;
  rsp_t predicted;
  int   rsp_count;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 20) begin
      $display("[%0t] checker: %s", $time, what);
    end
  endtask

  // set/reset word with the masked pins driven high (low half) or low (high half)
  function automatic logic [WORD_W-1:0] drive_pins(input logic [WORD_W-1:0] w,
                                                   input logic [MASK_W-1:0] m,
                                                   input bit high);
    if (high) begin
      return {w[31:16] & ~m, w[15:0] | m};
    end
    return {w[31:16] | m, w[15:0] & ~m};
  endfunction

  // apply one request beat to the predicted state and work out its response
  task automatic predict_beat(input req_t r, output rsp_t res);
    int pin;
    int duty;
    int old;
    res = '0;
    if (r.port_select == PORT_A) begin
      case (r.mode)
        MODE_SET: begin
          res.accepted = 1'b1;
          pin = PINS;
          for (int k = PINS - 1; k >= 0; k--) begin
            if (r.pin_mask[k]) pin = k;
          end
          duty = (r.duty_steps > STEPS) ? STEPS : int'(r.duty_steps);
          if (pin < PINS) begin
            if (!duty_known[pin]) begin
              // first write on this pin: every entry is rewritten
              for (int e = 0; e < STEPS; e++) begin
                pattern_mem[e] = drive_pins(pattern_mem[e], r.pin_mask, e < duty);
              end
              duty_known[pin] = 1'b1;
            end else begin
              // cached pin: only the entries between old and new duty move
              old = pin_duty[pin];
              for (int e = old; e < duty; e++) begin
                pattern_mem[e] = drive_pins(pattern_mem[e], r.pin_mask, 1'b1);
              end
              for (int e = duty; e < old; e++) begin
                pattern_mem[e] = drive_pins(pattern_mem[e], r.pin_mask, 1'b0);
              end
            end
            pin_duty[pin] = duty;
          end
        end
        MODE_CLEAR: begin
          res.accepted = 1'b1;
          for (int e = 0; e < STEPS; e++) begin
            pattern_mem[e] = '0;
          end
          duty_known = '0;
        end
        MODE_READ: begin
          res.accepted = 1'b1;
          if (r.entry_index < STEPS) res.pattern_word = pattern_mem[r.entry_index];
        end
        default: begin
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < STEPS; e++) begin
        pattern_mem[e] = '0;
      end
      for (int k = 0; k < PINS; k++) begin
        pin_duty[k] = 0;
      end
      duty_known = '0;
      expected_rsp.delete();
      rsp_count = 0;
    end else begin
      // response beat against the oldest prediction
      if (done) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch($sformatf("response %0d with no request outstanding: acc %b word %h",
                                    rsp_count, rsp.accepted, rsp.pattern_word));
        end else begin
          oldest = expected_rsp.pop_front();
          if (rsp.accepted !== oldest.accepted) begin
            report_mismatch($sformatf("response %0d accepted %b, predicted %b",
                                      rsp_count, rsp.accepted, oldest.accepted));
          end
          if (rsp.pattern_word !== oldest.pattern_word) begin
            report_mismatch($sformatf("response %0d pattern_word %h, predicted %h",
                                      rsp_count, rsp.pattern_word, oldest.pattern_word));
          end
        end
        rsp_count++;
      end
      // request beat taken: queue its predicted response
      if (start && !busy) begin
        predict_beat(req, predicted);
        expected_rsp.push_back(predicted);
      end
      // end of run: anything still queued never came back
      if (drain_check && expected_rsp.size() > 0) begin
        report_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));
        expected_rsp.delete();
      end
    end
    pending <= expected_rsp.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: request stimulus and verdict for the pwm pattern buffer updater
// depends on pbu_pkg, pwm_pattern_buffer_updater and pbu_checker
module tb_top import pbu_pkg::*; ();

  localparam int STEPS           = 256;
  localparam int PINS            = 16;
  localparam int BEATS_PER_PHASE = 120;

  logic clk         = 1'b0;
  logic rst         = 1'b1;
  logic start       = 1'b0;
  req_t req         = '0;
  logic drain_check = 1'b0;
  logic busy;
  logic done;
  rsp_t rsp;
  int   pending;
  int   errors;

  // sender idle percentage per phase; the first and third phases have no sender gaps
  int idle_pct [4] = '{0, 78, 0, 36};
  int n_set     = 0;
  int n_clear   = 0;
  int n_read    = 0;
  int n_refused = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pwm_pattern_buffer_updater #(
    .STEPS(STEPS),
    .PINS (PINS)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  pbu_checker #(
    .STEPS(STEPS),
    .PINS (PINS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .drain_check(drain_check),
    .pending    (pending),
    .errors     (errors)
  );

  // hard stop well beyond the slowest legal run
  initial begin
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic req_t make_beat(input logic [1:0] m, input logic [3:0] p,
                                     input logic [15:0] pins, input logic [15:0] d,
                                     input logic [7:0] i);
    req_t r;
    r.mode        = m;
    r.port_select = p;
    r.pin_mask    = pins;
    r.duty_steps  = d;
    r.entry_index = i;
    return r;
  endfunction

  // mostly served duty writes and reads, some clears, the rest refused noise
  function automatic req_t random_beat();
    req_t r;
    int   pick;
    int   pin;
    r.mode        = 2'($urandom);
    r.port_select = PORT_A;
    r.pin_mask    = 16'($urandom);
    r.duty_steps  = 16'($urandom);
    r.entry_index = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      r.mode = MODE_SET;
      pin = $urandom_range(PINS - 1);
      case ($urandom_range(9))
        7: r.pin_mask = 16'($urandom);
        8: r.pin_mask = '0;
        9: r.pin_mask = (16'h1 << pin) | (16'($urandom) << pin);
        default: r.pin_mask = 16'h1 << pin;
      endcase
      r.duty_steps = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(STEPS));
    end else if (pick < 80) begin
      r.mode = MODE_READ;
    end else if (pick < 84) begin
      r.mode = MODE_CLEAR;
    end else if (pick < 92) begin
      r.port_select = 4'($urandom_range(15, 1));
    end else begin
      r.mode = MODE_UNUSED;
    end
    return r;
  endfunction

  // hold one request beat until the block takes it
  task automatic send_beat(input req_t r);
    if (r.port_select != PORT_A) n_refused++;
    else if (r.mode == MODE_SET) n_set++;
    else if (r.mode == MODE_CLEAR) n_clear++;
    else if (r.mode == MODE_READ) n_read++;
    else n_refused++;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic sender_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop sending until every outstanding response has come back
  task automatic wait_drained();
    int guard;
    guard = 0;
    start <= 1'b0;
    do begin
      @(negedge clk);
      guard++;
    end while (pending != 0 && guard < 20 * STEPS);
    @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: store edges, saturation, pin masks, cached walks, refusals, clear
    send_beat(make_beat(MODE_READ,   PORT_A, 16'h0000, 16'h0000, 8'd0));
    send_beat(make_beat(MODE_READ,   PORT_A, 16'hffff, 16'hffff, 8'd255));
    send_beat(make_beat(MODE_SET,    PORT_A, 16'h0001, 16'h0000, 8'd0));
    send_beat(make_beat(MODE_READ,   PORT_A, 16'h0000, 16'h0000, 8'd0));
    send_beat(make_beat(MODE_SET,    PORT_A, 16'h8000, 16'hffff, 8'hff));
    send_beat(make_beat(MODE_READ,   PORT_A, 16'h0000, 16'h0000, 8'd255));
    send_beat(make_beat(MODE_SET,    PORT_A, 16'h0000, 16'd5,    8'd0));
    send_beat(make_beat(MODE_SET,    PORT_A, 16'h00f0, 16'd100,  8'd0));
    send_beat(make_beat(MODE_SET,    PORT_A, 16'h0010, 16'd40,   8'd0));
    send_beat(make_beat(MODE_SET,    PORT_A, 16'h0030, 16'd200,  8'd0));
    send_beat(make_beat(MODE_SET,    PORT_A, 16'h0010, 16'd200,  8'd0));
    send_beat(make_beat(MODE_READ,   PORT_A, 16'h0000, 16'h0000, 8'd39));
    send_beat(make_beat(MODE_READ,   PORT_A, 16'h0000, 16'h0000, 8'd40));
    send_beat(make_beat(MODE_READ,   PORT_A, 16'h0000, 16'h0000, 8'd199));
    send_beat(make_beat(MODE_SET,    4'd5,   16'hffff, 16'd7,    8'd0));
    send_beat(make_beat(MODE_READ,   4'd15,  16'h0000, 16'h0000, 8'haa));
    send_beat(make_beat(MODE_UNUSED, PORT_A, 16'hffff, 16'hffff, 8'hff));
    send_beat(make_beat(MODE_CLEAR,  PORT_A, 16'h0000, 16'h0000, 8'd0));
    send_beat(make_beat(MODE_READ,   PORT_A, 16'h0000, 16'h0000, 8'd100));
    send_beat(make_beat(MODE_SET,    PORT_A, 16'hffff, 16'd256,  8'd0));
    send_beat(make_beat(MODE_SET,    PORT_A, 16'hffff, 16'd1,    8'd0));
    send_beat(make_beat(MODE_READ,   PORT_A, 16'h0000, 16'h0000, 8'd0));
    send_beat(make_beat(MODE_READ,   PORT_A, 16'h0000, 16'h0000, 8'd1));
    send_beat(make_beat(MODE_CLEAR,  PORT_A, 16'h0000, 16'h0000, 8'd0));
    wait_drained();

    // random phases, each ended by a full drain
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        sender_gap(idle_pct[ph]);
        send_beat(random_beat());
      end
      wait_drained();
    end

    // let any late beat show up, then flag what is still outstanding
    repeat (STEPS + 8) @(posedge clk);
    drain_check <= 1'b1;
    @(posedge clk);
    drain_check <= 1'b0;
    @(negedge clk);

    $display("covered %0d requests: %0d duty writes, %0d clears, %0d reads, %0d refused",
             n_set + n_clear + n_read + n_refused, n_set, n_clear, n_read, n_refused);
    $display("over four sender pacing phases with a full drain between them");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/pbu_pkg.sv
hdl/pbu_store.sv
hdl/pbu_walk.sv
hdl/pwm_pattern_buffer_updater.sv
tb/pbu_checker.sv
tb/tb_top.sv
